// ----- hw/rtl/skht_pkg.sv -----
// Shared types, constants and crypt-table function for the hash slot table.
package skht_pkg;

    localparam int HASH_W  = 32;
    localparam int CHAR_W  = 8;
    localparam int CFG_W   = 11;
    localparam int SLOT_W  = 10;
    localparam int CRYPT_N = 1280;

    localparam logic [31:0] MIX_ONE_SEED = 32'h7FED7FED;
    localparam logic [31:0] MIX_TWO_SEED = 32'hEEEEEEEE;

    localparam logic [1:0] ACT_LOOKUP  = 2'd0;
    localparam logic [1:0] ACT_INSERT  = 2'd1;
    localparam logic [1:0] ACT_RELEASE = 2'd2;
    localparam logic [1:0] ACT_UPDATE  = 2'd3;

    localparam logic [1:0] ST_HIT      = 2'd0;
    localparam logic [1:0] ST_MISS     = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_INSERTED = 2'd3;

    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  key_char;
        logic        key_last;
        logic [31:0] payload_in;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [9:0]  slot;
        logic [31:0] payload_out;
    } rsp_t;

    // Finished key handed from hashing front to probing back.
    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] offset_hash;
        logic [31:0] check_a;
        logic [31:0] check_b;
        logic [31:0] payload;
    } job_t;

    typedef logic [31:0] crypt_arr_t [CRYPT_N];

    // Seeded generator, evaluated at elaboration into a constant table.
    function automatic crypt_arr_t build_crypt();
        crypt_arr_t  w;
        logic [63:0] seed;
        logic [31:0] hi;
        logic [31:0] lo;
        seed = 64'h00100001;
        for (int col = 0; col < 256; col++) begin
            for (int row = 0; row < 5; row++) begin
                seed = (seed * 64'd125 + 64'd3) % 64'h2AAAAB;
                hi   = {seed[15:0], 16'h0000};
                seed = (seed * 64'd125 + 64'd3) % 64'h2AAAAB;
                lo   = {16'h0000, seed[15:0]};
                w[col + row * 256] = hi | lo;
            end
        end
        return w;
    endfunction

    localparam crypt_arr_t CRYPT = build_crypt();

endpackage

// ----- hw/rtl/skht_ram.sv -----
// Generic single-port RAM with registered read.
module skht_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// ----- hw/rtl/skht_front.sv -----
// Front end: upper-cases key bytes and folds them into the three hashes.
module skht_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    input  skht_pkg::req_t req,
    output logic          job_valid,
    output skht_pkg::job_t job
);
    logic [31:0] mix_one_reg [3];
    logic [31:0] mix_two_reg [3];
    logic [31:0] mix_one_next [3];
    logic [31:0] mix_two_next [3];
    logic [7:0]  ch;

    always_comb
    begin
        ch = req.key_char;
        if (ch >= 8'h61 && ch <= 8'h7A)
        begin
            ch = ch - 8'h20;
        end
        for (int t = 0; t < 3; t++)
        begin
            mix_one_next[t] = skht_pkg::CRYPT[t * 256 + int'(ch)]
                              ^ (mix_one_reg[t] + mix_two_reg[t]);
            mix_two_next[t] = {24'h0, ch} + mix_one_next[t] + mix_two_reg[t]
                              + {mix_two_reg[t][26:0], 5'b0} + 32'd3;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int t = 0; t < 3; t++)
            begin
                mix_one_reg[t] <= skht_pkg::MIX_ONE_SEED;
                mix_two_reg[t] <= skht_pkg::MIX_TWO_SEED;
            end
            job_valid <= 1'b0;
        end
        else
        begin
            job_valid <= req_valid && req.key_last;
            if (req_valid)
            begin
                for (int t = 0; t < 3; t++)
                begin
                    mix_one_reg[t] <= req.key_last ? skht_pkg::MIX_ONE_SEED : mix_one_next[t];
                    mix_two_reg[t] <= req.key_last ? skht_pkg::MIX_TWO_SEED : mix_two_next[t];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req.key_last)
        begin
            job.action      <= req.action;
            job.offset_hash <= mix_one_next[0];
            job.check_a     <= mix_one_next[1];
            job.check_b     <= mix_one_next[2];
            job.payload     <= req.payload_in;
        end
    end
endmodule

// ----- hw/rtl/skht_back.sv -----
// Back end: start-slot reduction, clearing sweep and linear probe sequencer.
module skht_back #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [10:0]               slots_cfg,
    input  logic                      job_valid,
    input  skht_pkg::job_t            job,
    output logic                      ready,
    output logic                      rsp_valid,
    output skht_pkg::rsp_t            rsp
);
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int DW = 1 + 64 + 32;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_MOD   = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_CHECK = 3'd4;
    localparam logic [2:0] S_FREE  = 3'd5;
    localparam logic [2:0] S_RESP  = 3'd6;

    logic [2:0]    state_reg, state_next;
    skht_pkg::job_t job_reg;
    logic [31:0]   rem_reg, rem_next;
    logic [5:0]    bit_reg, bit_next;
    logic [16:0]   n_reg;
    logic [AW-1:0] start_reg, pos_reg, pos_next, free_reg, free_next;
    logic          free_ok_reg, free_ok_next;
    logic [AW:0]   clr_reg, clr_next;
    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [DW-1:0] ram_wdata, ram_rdata;
    logic          r_used;
    logic [31:0]   r_a, r_b, r_pay;
    logic [AW-1:0] pos_inc;
    logic          wrapped;
    logic [48:0]   trial;
    logic [16:0]   n_eff;
    skht_pkg::rsp_t rsp_next;
    logic          rsp_fire;

    assign {r_used, r_a, r_b, r_pay} = ram_rdata;

    always_comb
    begin
        if (slots_cfg == 11'd0)
            n_eff = 17'd1;
        else if ({6'd0, slots_cfg} > 17'(TABLE_DEPTH))
            n_eff = 17'(TABLE_DEPTH);
        else
            n_eff = {6'd0, slots_cfg};
    end

    skht_ram #(.WIDTH(DW), .DEPTH(TABLE_DEPTH)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign pos_inc = ({1'b0, pos_reg} + 1'b1 == 17'(n_reg)) ? '0 : pos_reg + 1'b1;
    assign wrapped = (pos_inc == start_reg);
    assign trial   = {17'd0, rem_reg} - ({32'd0, n_reg} << bit_reg);
    assign ready   = (state_reg == S_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        rem_next     = rem_reg;
        bit_next     = bit_reg;
        pos_next     = pos_reg;
        free_next    = free_reg;
        free_ok_next = free_ok_reg;
        clr_next     = clr_reg;
        ram_we       = 1'b0;
        ram_addr     = pos_reg;
        ram_wdata    = {r_used, r_a, r_b, r_pay};
        rsp_fire     = 1'b0;
        rsp_next     = '0;
        rsp_next.status = skht_pkg::ST_MISS;
        case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_addr  = clr_reg[AW-1:0];
                ram_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == (AW+1)'(TABLE_DEPTH - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (job_valid)
                begin
                    rem_next   = job.offset_hash;
                    bit_next   = 6'd31;
                    state_next = S_MOD;
                end
            end
            S_MOD:
            begin
                // restoring division, one quotient bit per cycle
                if (!trial[48])
                    rem_next = trial[31:0];
                bit_next = bit_reg - 1'b1;
                if (bit_reg == 6'd0)
                begin
                    pos_next     = rem_next[AW-1:0];
                    free_ok_next = 1'b0;
                    state_next   = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (!r_used)
                begin
                    if (!free_ok_reg)
                    begin
                        free_next    = pos_reg;
                        free_ok_next = 1'b1;
                    end
                    state_next = S_FREE;
                end
                else if (r_a == job_reg.check_a && r_b == job_reg.check_b)
                begin
                    rsp_fire = 1'b1;
                    rsp_next.status = skht_pkg::ST_HIT;
                    rsp_next.slot   = skht_pkg::SLOT_W'(pos_reg);
                    rsp_next.payload_out = r_pay;
                    if (job_reg.action == skht_pkg::ACT_RELEASE)
                    begin
                        ram_we    = 1'b1;
                        ram_wdata = {1'b0, r_a, r_b, r_pay};
                    end
                    else if (job_reg.action == skht_pkg::ACT_UPDATE)
                    begin
                        ram_we    = 1'b1;
                        ram_wdata = {r_used, r_a, r_b, job_reg.payload};
                        rsp_next.payload_out = job_reg.payload;
                    end
                    state_next = S_RESP;
                end
                else if (wrapped)
                    state_next = S_FREE;
                else
                begin
                    pos_next   = pos_inc;
                    state_next = S_READ;
                end
            end
            S_FREE:
            begin
                // first unused slot from start is the insertion point
                if (job_reg.action != skht_pkg::ACT_INSERT)
                    rsp_fire = 1'b1;
                else if (!free_ok_reg)
                begin
                    rsp_fire = 1'b1;
                    rsp_next.status = skht_pkg::ST_FULL;
                end
                else
                begin
                    rsp_fire  = 1'b1;
                    ram_we    = 1'b1;
                    ram_addr  = free_reg;
                    ram_wdata = {1'b1, job_reg.check_a, job_reg.check_b, job_reg.payload};
                    rsp_next.status = skht_pkg::ST_INSERTED;
                    rsp_next.slot   = skht_pkg::SLOT_W'(free_reg);
                    rsp_next.payload_out = job_reg.payload;
                end
                state_next = S_RESP;
            end
            S_RESP:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            rsp_valid <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            rsp_valid <= rsp_fire;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg     <= rem_next;
        bit_reg     <= bit_next;
        pos_reg     <= pos_next;
        free_reg    <= free_next;
        free_ok_reg <= free_ok_next;
        if (state_reg == S_MOD && bit_reg == 6'd0)
            start_reg <= rem_next[AW-1:0];
        if (state_reg == S_IDLE && job_valid)
        begin
            job_reg <= job;
            n_reg   <= n_eff;
        end
        if (rsp_fire)
            rsp <= rsp_next;
    end
endmodule

// ----- hw/rtl/string_keyed_hash_slot_table_core.sv -----
// Top level of the string-keyed hash slot table.
// Usage: drive key bytes with start; a byte is taken when start is high and
// busy is low. Ordinary bytes do not raise busy. The byte with key_last set
// closes the key: a bit-serial reduction picks the start slot, then the
// probe sequencer reads and checks each slot visited in turn (one RAM read port).
// One request in flight per key end; busy stays high until its result.
// The result shows on status/slot/payload_out for one cycle with done; the
// receiver cannot stall, so results are never held.
// The next byte can be taken once busy falls: the back end has returned from
// S_RESP to S_IDLE and the pending flag has cleared on done.
// slots_in_use is written via cfg_we/cfg_data; the user must write it while
// idle, as the block does not enforce this; reset 1024.
// After reset every slot of the RAM is swept to zero with busy high.
module string_keyed_hash_slot_table_core #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  skht_pkg::req_t   req,
    output logic             done,
    output skht_pkg::rsp_t   rsp,
    input  logic             cfg_we,
    input  logic [10:0]      cfg_data
);
    logic [10:0]    slots_reg;
    logic           job_valid, back_ready, pend_reg, accept;
    skht_pkg::job_t job;

    assign accept = start && !busy;
    assign busy   = !back_ready || job_valid || pend_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slots_reg <= 11'd1024;
            pend_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                slots_reg <= cfg_data;
            if (job_valid && back_ready)
                pend_reg <= 1'b1;
            else if (done)
                pend_reg <= 1'b0;
        end
    end

    skht_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (accept),
        .req       (req),
        .job_valid (job_valid),
        .job       (job)
    );

    skht_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .slots_cfg (slots_reg),
        .job_valid (job_valid),
        .job       (job),
        .ready     (back_ready),
        .rsp_valid (done),
        .rsp       (rsp)
    );
endmodule

// ----- hw/rtl/skht_checker.sv -----
// Port-level checks for the hash slot table, bound to the top level.
module skht_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           start,
    input logic           busy,
    input logic           done,
    input skht_pkg::rsp_t rsp
);
    a_done_one: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("result strobe longer than a cycle");
    a_busy_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy) else $error("busy low while a result is shown");
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (rsp.status == skht_pkg::ST_MISS || rsp.status == skht_pkg::ST_FULL))
        |-> (rsp.slot == 10'd0 && rsp.payload_out == 32'd0))
        else $error("miss or full result carries data");
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy)) else $error("result without a key in flight");
endmodule

bind string_keyed_hash_slot_table_core skht_checker u_skht_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done),
    .rsp   (rsp)
);

// ----- verif/string_keyed_hash_slot_table_core_test.sv -----
// Testbench for the string-keyed hash slot table: key streams against a shadow table.
`timescale 1ns / 100ps

module string_keyed_hash_slot_table_core_test;

    localparam int DEPTH = 1024;
    localparam int STALL_LIMIT = 20000;

    class hash_slot_scoreboard;
        logic [31:0] crypt_word [1280];
        bit          used [DEPTH];
        logic [31:0] chk_a [DEPTH];
        logic [31:0] chk_b [DEPTH];
        logic [31:0] pay [DEPTH];
        logic [31:0] mix1 [3];
        logic [31:0] mix2 [3];
        logic [10:0] slots_reg;
        skht_pkg::rsp_t awaited [$];
        int          errors;

        function new();
            logic [63:0] seed;
            logic [31:0] hi;
            seed = 64'h00100001;
            for (int c = 0; c < 256; c++) begin
                for (int r = 0; r < 5; r++) begin
                    seed = (seed * 125 + 3) % 64'h2AAAAB;
                    hi   = {seed[15:0], 16'h0000};
                    seed = (seed * 125 + 3) % 64'h2AAAAB;
                    crypt_word[c + r * 256] = hi | {16'h0000, seed[15:0]};
                end
            end
            for (int i = 0; i < DEPTH; i++) begin
                used[i] = 0;
                chk_a[i] = '0;
                chk_b[i] = '0;
                pay[i] = '0;
            end
            for (int t = 0; t < 3; t++) begin
                mix1[t] = skht_pkg::MIX_ONE_SEED;
                mix2[t] = skht_pkg::MIX_TWO_SEED;
            end
            slots_reg = 11'd1024;
            errors = 0;
        endfunction

        function void set_slots(logic [10:0] v);
            slots_reg = v;
        endfunction

        function void note_request(skht_pkg::req_t r);
            logic [31:0] ch, s1, s2, n, start_pos, ha, hb, p;
            skht_pkg::rsp_t res;
            bit hit, full;
            ch = {24'h0, r.key_char};
            if (ch >= 32'h61 && ch <= 32'h7A) ch = ch - 32'h20;
            for (int t = 0; t < 3; t++) begin
                s1 = crypt_word[t * 256 + ch] ^ (mix1[t] + mix2[t]);
                s2 = ch + s1 + mix2[t] + (mix2[t] << 5) + 3;
                mix1[t] = s1;
                mix2[t] = s2;
            end
            if (!r.key_last) return;
            n = (slots_reg == 0) ? 1 : (slots_reg > DEPTH) ? DEPTH : slots_reg;
            start_pos = mix1[0] % n;
            ha = mix1[1];
            hb = mix1[2];
            for (int t = 0; t < 3; t++) begin
                mix1[t] = skht_pkg::MIX_ONE_SEED;
                mix2[t] = skht_pkg::MIX_TWO_SEED;
            end
            res = '{status: skht_pkg::ST_MISS, slot: '0, payload_out: '0};
            hit = 0;
            p = start_pos;
            while (used[p]) begin
                if (chk_a[p] == ha && chk_b[p] == hb) begin
                    hit = 1;
                    break;
                end
                p = (p + 1) % n;
                if (p == start_pos) break;
            end
            if (hit) begin
                if (r.action == skht_pkg::ACT_RELEASE) used[p] = 0;
                else if (r.action == skht_pkg::ACT_UPDATE) pay[p] = r.payload_in;
                res = '{status: skht_pkg::ST_HIT, slot: p[9:0], payload_out: pay[p]};
            end else if (r.action == skht_pkg::ACT_INSERT) begin
                full = 0;
                p = start_pos;
                while (used[p]) begin
                    p = (p + 1) % n;
                    if (p == start_pos) begin
                        full = 1;
                        break;
                    end
                end
                if (full) res.status = skht_pkg::ST_FULL;
                else begin
                    used[p] = 1;
                    chk_a[p] = ha;
                    chk_b[p] = hb;
                    pay[p] = r.payload_in;
                    res = '{status: skht_pkg::ST_INSERTED, slot: p[9:0],
                            payload_out: r.payload_in};
                end
            end
            awaited.insert(awaited.size(), res);
        endfunction

        task report(string msg);
            $display("mismatch @%0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(skht_pkg::rsp_t got);
            skht_pkg::rsp_t want;
            if (awaited.size() == 0) begin
                report($sformatf("unexpected result %p", got));
                return;
            end
            want = awaited.pop_front();
            if (got.status !== want.status)
                report($sformatf("status %0d, want %0d", got.status, want.status));
            if (got.slot !== want.slot)
                report($sformatf("slot %0d, want %0d", got.slot, want.slot));
            if (got.payload_out !== want.payload_out)
                report($sformatf("payload %h, want %h", got.payload_out, want.payload_out));
        endtask
    endclass

    logic           clk = 0;
    logic           rst_n = 0;
    logic           start = 0;
    logic           busy;
    skht_pkg::req_t req = '0;
    logic           done;
    skht_pkg::rsp_t rsp;
    logic           cfg_we = 0;
    logic [10:0]    cfg_data = '0;

    hash_slot_scoreboard sb = new();
    int idle_cycles = 0;

    logic [7:0] key_bytes [10][8];
    int         key_len [10];

    string_keyed_hash_slot_table_core dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .req(req),
        .done(done), .rsp(rsp), .cfg_we(cfg_we), .cfg_data(cfg_data)
    );

    always
    begin
        #4 clk = 1;
        #4 clk = 0;
    end

    always @(posedge clk)
    begin
        if (rst_n && start && !busy) sb.note_request(req);
        if (rst_n && done) sb.check_result(rsp);
        if ((start && !busy) || done) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("** string_keyed_hash_slot_table_core: FAILED **");
            $finish;
        end
    end

    task send_byte(logic [1:0] act, logic [7:0] ch, logic last, logic [31:0] pl);
        int gap;
        gap = $urandom_range(0, 7);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            start <= 0;
            repeat (gap) @(posedge clk);
        end
        start <= 1;
        req <= '{action: act, key_char: ch, key_last: last, payload_in: pl};
        do @(negedge clk); while (busy);
        @(posedge clk);
    endtask

    task send_key(int k, logic [1:0] act, logic [31:0] pl);
        for (int i = 0; i < key_len[k]; i++)
            if (i == key_len[k] - 1) send_byte(act, key_bytes[k][i], 1, pl);
            else send_byte(2'($urandom), key_bytes[k][i], 0, $urandom);
    endtask

    task drain();
        start <= 0;
        while (sb.awaited.size() != 0) @(posedge clk);
        repeat (80) @(posedge clk);
        do @(negedge clk); while (busy);
        @(posedge clk);
    endtask

    task write_slots(logic [10:0] v);
        cfg_we <= 1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 0;
        sb.set_slots(v);
    endtask

    task fresh_keys();
        for (int k = 0; k < 10; k++) begin
            key_len[k] = ($urandom_range(0, 4) == 0) ? 8 : $urandom_range(1, 4);
            for (int i = 0; i < 8; i++)
                key_bytes[k][i] = ($urandom_range(0, 1) == 0) ? 8'($urandom)
                                                             : 8'($urandom_range(8'h41, 8'h5A));
        end
        // lower-cased twin of key 0
        key_len[1] = key_len[0];
        for (int i = 0; i < 8; i++)
            key_bytes[1][i] = (key_bytes[0][i] >= 8'h41 && key_bytes[0][i] <= 8'h5A)
                              ? key_bytes[0][i] + 8'h20 : key_bytes[0][i];
    endtask

    initial
    begin
        logic [10:0] slot_settings [6];
        int roll;
        slot_settings = '{11'd1024, 11'd1, 11'd7, 11'd0, 11'd2047, 11'd16};
        repeat (12) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        do @(negedge clk); while (busy);
        @(posedge clk);

        // directed: miss, insert, case fold, update, release, misses after release
        key_len[0] = 3;
        key_bytes[0][0] = 8'h61; key_bytes[0][1] = 8'h00; key_bytes[0][2] = 8'hFF;
        key_len[1] = 3;
        key_bytes[1][0] = 8'h41; key_bytes[1][1] = 8'h00; key_bytes[1][2] = 8'hFF;
        key_len[2] = 1;
        key_bytes[2][0] = 8'h7A;
        send_key(0, skht_pkg::ACT_LOOKUP, 32'h0);
        send_key(0, skht_pkg::ACT_INSERT, 32'hFFFF_FFFF);
        send_key(1, skht_pkg::ACT_INSERT, 32'h0);
        send_key(1, skht_pkg::ACT_LOOKUP, 32'h0);
        send_key(0, skht_pkg::ACT_UPDATE, 32'h0);
        send_key(2, skht_pkg::ACT_INSERT, 32'h1234_5678);
        send_key(0, skht_pkg::ACT_RELEASE, 32'h0);
        send_key(1, skht_pkg::ACT_RELEASE, 32'h0);
        send_key(0, skht_pkg::ACT_UPDATE, 32'h5);
        send_key(2, skht_pkg::ACT_LOOKUP, 32'h0);
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            write_slots(slot_settings[ph]);
            fresh_keys();
            for (int op = 0; op < 27; op++) begin
                roll = $urandom_range(0, 9);
                send_key($urandom_range(0, 9),
                         (roll < 4) ? skht_pkg::ACT_INSERT :
                         (roll < 6) ? skht_pkg::ACT_LOOKUP :
                         (roll < 8) ? skht_pkg::ACT_UPDATE : skht_pkg::ACT_RELEASE,
                         ($urandom_range(0, 7) == 0) ? 32'hFFFF_FFFF : $urandom);
            end
            drain();
        end

        if (sb.errors == 0 && sb.awaited.size() == 0)
            $display("** string_keyed_hash_slot_table_core: PASSED **");
        else
            $display("** string_keyed_hash_slot_table_core: FAILED **");
        $finish;
    end

endmodule
